// ----- rtl/pcp_pkg.sv -----
// Shared constants, types and sigmoid table for the phase congruency pixel unit.
`default_nettype none
package pcp_pkg;

    localparam int MAX_SCALES = 16;
    localparam int CNT_W      = $clog2(MAX_SCALES + 1);

    localparam int IN_W   = 16;                   // Q1.14 response width
    localparam int EPS_W  = 14;
    localparam int CFG_W  = 16;
    localparam int SUM_W  = 21;                   // signed response sums
    localparam int ASUM_W = 22;                   // amplitude sum
    localparam int PEAK_W = 17;                   // amplitude peak
    localparam int RAD_W  = 42;                   // radicand of the square root
    localparam int ROOT_W = RAD_W / 2;
    localparam int NUM_W  = ASUM_W + 16;          // dividend, scaled by 2^16
    localparam int DEN_W  = 23;                   // divisor
    localparam int OUT_W  = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam int SIG_DEPTH = 256;
    localparam int SIG_LOG   = $clog2(SIG_DEPTH);
    localparam int SIG_SHIFT = 30 - SIG_LOG;      // fraction bits of the table position
    localparam int U_W       = 32;                // |cutoff - spread| * gain
    localparam int IDX_W     = U_W - SIG_SHIFT;
    localparam int TAB_W     = 17;

    typedef enum logic [1:0] {
        CFG_EPSILON = 2'd0,
        CFG_GAIN    = 2'd1,
        CFG_CUTOFF  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [IN_W-1:0] even;
        logic signed [IN_W-1:0] first;
        logic signed [IN_W-1:0] second;
        logic                   close;     // pixel completes with this beat
    } t_item;

    typedef logic [TAB_W-1:0] t_sig_tab [SIG_DEPTH+1];

    // shift-subtract quotient, used only while the table is built
    function automatic logic [63:0] sig_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // g(u) = round(65536/(1+exp(u))), u = 16k/SIG_DEPTH, integer series for exp.
    function automatic t_sig_tab sig_build();
        t_sig_tab    tab;
        logic [63:0] v;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] one;
        one = 64'd1 << 31;
        for (int k = 0; k <= SIG_DEPTH; k++) begin
            v    = (64'(k) << 31) >> (4 + SIG_LOG);
            s    = one;
            term = one;
            for (int n = 1; n <= 7; n++) begin
                term = sig_div((term * v) >> 31, 64'(n));
                if ((n & 1) == 1) begin
                    s = s - term;
                end else begin
                    s = s + term;
                end
            end
            for (int i = 0; i < 8; i++) begin
                s = (s * s + (64'd1 << 30)) >> 31;
            end
            tab[k] = TAB_W'(sig_div((s << 16) + ((one + s) >> 1), one + s));
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = sig_build();

endpackage
`default_nettype wire

// ----- rtl/pcp_front.sv -----
// Input side: accepts scale beats, marks pixel-closing beats, queues them for the back end.
`default_nettype none
module pcp_front
    import pcp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic signed [IN_W-1:0] i_even_response,
    input  wire logic signed [IN_W-1:0] i_riesz_first,
    input  wire logic signed [IN_W-1:0] i_riesz_second,
    input  wire logic                   i_last_scale,
    input  wire logic                   i_pop,
    output logic                        o_avail,
    output t_item                       o_item
);

    t_item                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_PTR_W:0]     r_fill;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_close;

    assign o_in_stall = (r_fill == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_avail    = (r_fill != '0);
    assign o_item     = r_q[r_rd];
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && o_avail;
    assign n_cnt      = r_cnt + CNT_W'(1);
    assign w_close    = i_last_scale || (n_cnt == CNT_W'(MAX_SCALES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wr  <= r_wr + Q_PTR_W'(1);
                r_cnt <= w_close ? '0 : n_cnt;
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_fill <= r_fill + (Q_PTR_W+1)'(w_push) - (Q_PTR_W+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{even: i_even_response, first: i_riesz_first,
                           second: i_riesz_second, close: w_close};
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue fill above depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_fill != '0))
        else $error("pushed beat not visible");

endmodule
`default_nettype wire

// ----- rtl/pcp_sqrt.sv -----
// Bit-serial floor square root, one result bit per cycle.
`default_nettype none
module pcp_sqrt
    import pcp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int SC_W  = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SC_W-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_fit;

    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = REM_W'({r_root, 2'b01});
    assign w_fit    = (w_rem_sh >= w_trial);
    assign o_done   = r_done;
    assign o_root   = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + SC_W'(1);
                if (r_cnt == SC_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pcp_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
`default_nettype none
module pcp_div
    import pcp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic [OUT_W-1:0]       o_quot
);

    localparam int DC_W  = $clog2(NUM_W);
    localparam int REM_W = DEN_W + 1;

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DC_W-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W-1:0] w_rem_sh;
    logic             w_fit;

    assign w_rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});
    assign o_done   = r_done;

    // zero divisor gives zero; anything at or above 2^16 saturates
    always_comb begin
        if (r_den == '0) begin
            o_quot = '0;
        end else if (|r_q[NUM_W-1:OUT_W]) begin
            o_quot = '1;
        end else begin
            o_quot = r_q[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DC_W'(1);
                if (r_cnt == DC_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            if (w_fit) begin
                r_rem <= w_rem_sh - {1'b0, r_den};
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/phase_congruency_pixel_unit.sv -----
// Top level: per-pixel phase congruency from per-scale even and Riesz responses.
// Timing: a non-closing scale beat occupies the back end for three squares on one
//   multiplier, then the 21-step bit-serial square root.
// A closing beat adds the energy square root, two 38-step divisions and the
//   sigmoid/weight states SIG1 to SIG4; the result then appears on o_congruency.
// The back end works on one beat at a time, held by the shared square root; a 4-deep
//   queue absorbs short bursts. Reset (synchronous, active low) clears accumulators,
//   queue and output valid and loads epsilon=164, gain=10240, cutoff=26214.
`default_nettype none
module phase_congruency_pixel_unit
    import pcp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic signed [IN_W-1:0] i_even_response,
    input  wire logic signed [IN_W-1:0] i_riesz_first,
    input  wire logic signed [IN_W-1:0] i_riesz_second,
    input  wire logic                   i_last_scale,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [OUT_W-1:0]            o_congruency,
    // configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_MUL  = 13'b0000000000010,
        ST_ADD  = 13'b0000000000100,
        ST_ROOT = 13'b0000000001000,
        ST_UPD  = 13'b0000000010000,
        ST_DEN  = 13'b0000000100000,
        ST_DIV1 = 13'b0000001000000,
        ST_DIV2 = 13'b0000010000000,
        ST_SIG1 = 13'b0000100000000,
        ST_SIG2 = 13'b0001000000000,
        ST_SIG3 = 13'b0010000000000,
        ST_SIG4 = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } t_state;

    // config registers
    logic [EPS_W-1:0]  r_eps;
    logic [CFG_W-1:0]  r_gain;
    logic [CFG_W-1:0]  r_cut;

    // front/back handoff
    logic              w_avail;
    logic              w_pop;
    t_item             w_item;

    // sequencer
    t_state            r_state;
    t_state            n_state;
    logic [1:0]        r_sel;        // which operand is being squared
    logic              r_fin;        // squares belong to the energy, not an amplitude
    logic              r_close;

    // datapath
    logic signed [SUM_W-1:0] r_x [3];
    logic [RAD_W-1:0]  r_prod;
    logic [RAD_W-1:0]  r_acc;
    logic signed [SUM_W-1:0] r_es;
    logic signed [SUM_W-1:0] r_fs;
    logic signed [SUM_W-1:0] r_ss;
    logic [ASUM_W-1:0] r_asum;
    logic [PEAK_W-1:0] r_peak;
    logic [CNT_W-1:0]  r_cnt;
    logic [ROOT_W-1:0] r_energy;
    logic [DEN_W-1:0]  r_sden;
    logic [OUT_W-1:0]  r_ratio;
    logic [OUT_W-1:0]  r_spread;
    logic              r_neg;
    logic [U_W-1:0]    r_u;
    logic [TAB_W-1:0]  r_t0;
    logic [TAB_W-1:0]  r_dlt;
    logic [SIG_SHIFT-1:0] r_frac;
    logic [TAB_W+SIG_SHIFT-1:0] r_ip;
    logic [OUT_W+TAB_W-1:0]     r_wp;

    logic signed [RAD_W-1:0] w_opx;
    logic signed [RAD_W-1:0] w_sq;
    logic [RAD_W-1:0]  w_acc_next;
    logic              w_sq_start;
    logic              w_sq_done;
    logic [ROOT_W-1:0] w_root;
    logic signed [SUM_W-1:0] w_es_next;
    logic signed [SUM_W-1:0] w_fs_next;
    logic signed [SUM_W-1:0] w_ss_next;
    logic              w_div_start;
    logic [NUM_W-1:0]  w_div_num;
    logic [DEN_W-1:0]  w_div_den;
    logic              w_div_done;
    logic [OUT_W-1:0]  w_quot;
    logic [PEAK_W:0]   w_pe;
    logic signed [OUT_W:0] w_diff;
    logic [OUT_W-1:0]  w_mag;
    logic [IDX_W-1:0]  w_idx;
    logic              w_big;
    logic [SIG_LOG:0]  w_lo;
    logic [TAB_W-1:0]  w_t0;
    logic [TAB_W-1:0]  w_t1;
    logic [TAB_W-1:0]  w_g;
    logic [TAB_W-1:0]  w_w;
    logic              w_out_load;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= EPS_W'(164);
            r_gain <= CFG_W'(10240);
            r_cut  <= CFG_W'(26214);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EPSILON: r_eps  <= i_cfg_data[EPS_W-1:0];
                CFG_GAIN:    r_gain <= i_cfg_data;
                CFG_CUTOFF:  r_cut  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // ---------------- front: accept and classify ----------------
    pcp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_even_response (i_even_response),
        .i_riesz_first   (i_riesz_first),
        .i_riesz_second  (i_riesz_second),
        .i_last_scale    (i_last_scale),
        .i_pop           (w_pop),
        .o_avail         (w_avail),
        .o_item          (w_item)
    );

    assign w_pop = (r_state == ST_IDLE) && w_avail;

    // ---------------- shared square root ----------------
    // each 21x21 square is registered in MUL, summed in ADD, then rooted bit-serially
    assign w_opx      = RAD_W'(r_x[r_sel]);
    assign w_sq       = w_opx * w_opx;
    assign w_acc_next = r_acc + r_prod;
    assign w_sq_start = (r_state == ST_ADD) && (r_sel == 2'd2);

    pcp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_acc_next),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_es_next = r_es + r_x[0];
    assign w_fs_next = r_fs + r_x[1];
    assign w_ss_next = r_ss + r_x[2];

    // ---------------- shared divider ----------------
    // first energy/(amp_sum+eps), then amp_sum/((peak+eps)*count)
    assign w_pe = (PEAK_W+1)'(r_peak) + (PEAK_W+1)'(r_eps);
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = NUM_W'({r_energy, 16'b0});
        w_div_den   = DEN_W'(r_asum) + DEN_W'(r_eps);
        if (r_state == ST_DEN) begin
            w_div_start = 1'b1;
        end else if (r_state == ST_DIV1 && w_div_done) begin
            w_div_start = 1'b1;
            w_div_num   = {r_asum, 16'b0};
            w_div_den   = r_sden;
        end
    end

    pcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---------------- sigmoid weight ----------------
    assign w_diff = (OUT_W+1)'({1'b0, r_cut}) - (OUT_W+1)'({1'b0, r_spread});
    assign w_mag  = w_diff[OUT_W] ? OUT_W'(-w_diff) : w_diff[OUT_W-1:0];
    assign w_idx  = r_u[U_W-1:SIG_SHIFT];
    assign w_big  = (w_idx >= IDX_W'(SIG_DEPTH));
    assign w_lo   = {1'b0, w_idx[SIG_LOG-1:0]};
    assign w_t0   = SIG_TABLE[w_lo];
    assign w_t1   = SIG_TABLE[w_lo + (SIG_LOG+1)'(1)];
    // beyond the table the delta is zero, so the last entry passes straight through
    assign w_g    = r_t0 - TAB_W'(r_ip >> SIG_SHIFT);
    assign w_w    = r_neg ? (TAB_W'(65536) - w_g) : w_g;

    assign w_out_load = (r_state == ST_OUT) && (!o_out_valid || !i_out_stall);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_avail) n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = (r_sel == 2'd2) ? ST_ROOT : ST_MUL;
            ST_ROOT: begin
                if (w_sq_done) n_state = r_fin ? ST_DEN : ST_UPD;
            end
            ST_UPD:  n_state = r_close ? ST_MUL : ST_IDLE;
            ST_DEN:  n_state = ST_DIV1;
            ST_DIV1: if (w_div_done) n_state = ST_DIV2;
            ST_DIV2: if (w_div_done) n_state = ST_SIG1;
            ST_SIG1: n_state = ST_SIG2;
            ST_SIG2: n_state = ST_SIG3;
            ST_SIG3: n_state = ST_SIG4;
            ST_SIG4: n_state = ST_OUT;
            ST_OUT:  if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= '0;
            r_fin       <= 1'b0;
            r_close     <= 1'b0;
            r_es        <= '0;
            r_fs        <= '0;
            r_ss        <= '0;
            r_asum      <= '0;
            r_peak      <= '0;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new result may replace one taken in the same cycle
            if (w_out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_avail) begin
                        r_sel   <= '0;
                        r_fin   <= 1'b0;
                        r_close <= w_item.close;
                    end
                end
                ST_ADD: begin
                    r_sel <= r_sel + 2'd1;
                end
                ST_UPD: begin
                    r_es   <= w_es_next;
                    r_fs   <= w_fs_next;
                    r_ss   <= w_ss_next;
                    r_asum <= r_asum + ASUM_W'(w_root);
                    if (PEAK_W'(w_root) > r_peak) begin
                        r_peak <= PEAK_W'(w_root);
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_sel <= '0;
                    r_fin <= 1'b1;
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_es   <= '0;
                        r_fs   <= '0;
                        r_ss   <= '0;
                        r_asum <= '0;
                        r_peak <= '0;
                        r_cnt  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x[0] <= SUM_W'(w_item.even);
                r_x[1] <= SUM_W'(w_item.first);
                r_x[2] <= SUM_W'(w_item.second);
                r_acc  <= '0;
            end
            ST_MUL: r_prod <= w_sq;
            ST_ADD: r_acc  <= w_acc_next;
            ST_ROOT: begin
                if (w_sq_done) r_energy <= w_root;
            end
            ST_UPD: begin
                // closing beat: square the updated sums for the energy
                r_x[0] <= w_es_next;
                r_x[1] <= w_fs_next;
                r_x[2] <= w_ss_next;
                r_acc  <= '0;
            end
            ST_DEN: r_sden <= DEN_W'(w_pe) * DEN_W'(r_cnt);
            ST_DIV1: begin
                if (w_div_done) r_ratio <= w_quot;
            end
            ST_DIV2: begin
                if (w_div_done) r_spread <= w_quot;
            end
            ST_SIG1: begin
                r_neg <= w_diff[OUT_W];
                r_u   <= U_W'(w_mag) * U_W'(r_gain);
            end
            ST_SIG2: begin
                r_t0   <= w_big ? SIG_TABLE[SIG_DEPTH] : w_t0;
                r_dlt  <= w_big ? '0 : (w_t0 - w_t1);
                r_frac <= r_u[SIG_SHIFT-1:0];
            end
            ST_SIG3: r_ip <= (TAB_W+SIG_SHIFT)'(r_dlt) * (TAB_W+SIG_SHIFT)'(r_frac);
            ST_SIG4: r_wp <= (OUT_W+TAB_W)'(r_ratio) * (OUT_W+TAB_W)'(w_w);
            ST_OUT: begin
                if (w_out_load) o_congruency <= r_wp[2*OUT_W-1:OUT_W];
            end
            default: ;
        endcase
    end

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result beat raised outside output step");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SCALES))
        else $error("scale count past limit");

    a_root_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_start |=> (r_state == ST_ROOT))
        else $error("square root started outside root wait");

endmodule
`default_nettype wire

// ----- tb/phase_congruency_pixel_unit_test.sv -----
// Self-checking testbench for the phase congruency pixel unit.
module phase_congruency_pixel_unit_test;
    import pcp_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic signed [IN_W-1:0] i_even_response = '0;
    logic signed [IN_W-1:0] i_riesz_first = '0;
    logic signed [IN_W-1:0] i_riesz_second = '0;
    logic                   i_last_scale = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [OUT_W-1:0]       o_congruency;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    phase_congruency_pixel_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: registers, pixel accumulators and the sigmoid table.
    longint unsigned  eps_reg, gain_reg, cutoff_reg;
    longint           even_acc, first_acc, second_acc;
    longint unsigned  amp_acc, amp_peak, n_scales;
    longint unsigned  sig_lut [SIG_DEPTH+1];
    logic [OUT_W-1:0] congruency_q [$];
    int               n_errors = 0;
    int               idle_pct = 0;     // sender gap odds per beat, percent
    int               stall_pct = 0;    // receiver stall odds per cycle, percent
    int               open_scales = 0;  // scales sent for the pixel in progress

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // g(u) = round(65536/(1+exp(u))), exp(-u) from a series on u/256, squared 8 times.
    task automatic fill_sigmoid_lut();
        longint unsigned one, v, acc, term;
        one = 64'd1 << 31;
        for (int k = 0; k <= SIG_DEPTH; k++) begin
            v = (longint'(k) << 31) / (16 * SIG_DEPTH);
            acc = one;
            term = one;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * v) >> 31) / n;
                if (n % 2) acc -= term;
                else acc += term;
            end
            for (int i = 0; i < 8; i++) acc = (acc * acc + (64'd1 << 30)) >> 31;
            sig_lut[k] = ((acc << 16) + (one + acc) / 2) / (one + acc);
        end
    endtask

    function automatic logic [OUT_W-1:0] pixel_congruency();
        longint unsigned energy, den, ratio, sden, spread, u, pos, idx, frac, g, w;
        longint          diff;
        energy = int_sqrt(even_acc * even_acc + first_acc * first_acc
                          + second_acc * second_acc);
        den = amp_acc + eps_reg;
        ratio = (den != 0) ? (energy << 16) / den : 0;    // zero guard gives zero
        sden = (amp_peak + eps_reg) * n_scales;
        spread = (sden != 0) ? (amp_acc << 16) / sden : 0;
        if (ratio > 65535) ratio = 65535;
        if (spread > 65535) spread = 65535;
        diff = longint'(cutoff_reg) - longint'(spread);
        u = (diff < 0 ? -diff : diff) * gain_reg;
        pos = u * SIG_DEPTH;
        idx = pos >> 30;
        frac = pos & ((64'd1 << 30) - 1);
        // past the table end the last entry holds
        if (idx >= SIG_DEPTH) g = sig_lut[SIG_DEPTH];
        else g = sig_lut[idx] - (((sig_lut[idx] - sig_lut[idx+1]) * frac) >> 30);
        w = (diff >= 0) ? g : 65536 - g;
        return OUT_W'((ratio * w) >> 16);
    endfunction

    function automatic void clear_pixel_acc();
        even_acc = 0; first_acc = 0; second_acc = 0;
        amp_acc = 0; amp_peak = 0; n_scales = 0;
    endfunction

    function automatic void predict_scale(shortint e, shortint a, shortint b, bit last);
        longint unsigned amp;
        even_acc += e;
        first_acc += a;
        second_acc += b;
        amp = int_sqrt(longint'(e) * e + longint'(a) * a + longint'(b) * b);
        amp_acc += amp;
        if (amp > amp_peak) amp_peak = amp;
        n_scales++;
        // a pixel also closes on its sixteenth scale without the last flag
        if (last || n_scales >= MAX_SCALES) begin
            congruency_q.push_back(pixel_congruency());
            clear_pixel_acc();
        end
    endfunction

    // Send one scale beat; valid stays up into the next call unless a gap is drawn.
    task automatic send_scale(shortint e, shortint a, shortint b, bit last);
        i_in_valid <= 1'b1;
        i_even_response <= e;
        i_riesz_first <= a;
        i_riesz_second <= b;
        i_last_scale <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_scale(e, a, b, last);
        open_scales = (last || open_scales + 1 >= MAX_SCALES) ? 0 : open_scales + 1;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every pixel result is back and the back end drained.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (congruency_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_EPSILON: eps_reg = data & 16'h3FFF;
            CFG_GAIN:    gain_reg = data;
            default:     cutoff_reg = data;
        endcase
    endtask

    task automatic set_regs(logic [CFG_W-1:0] eps, logic [CFG_W-1:0] gain,
                            logic [CFG_W-1:0] cutoff);
        write_reg(CFG_EPSILON, eps);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_CUTOFF, cutoff);
    endtask

    function automatic shortint pick_response();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 0;
            3, 4:    return shortint'($urandom_range(0, 64)) - 32;
            default: return shortint'($urandom());
        endcase
    endfunction

    // Extremes, one-scale and multi-scale pixels under the reset register values.
    task automatic test_directed();
        send_scale(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_scale(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_scale(0, 0, 0, 1'b1);
        send_scale(16'sh7FFF, 0, 0, 1'b0);
        send_scale(16'sh8000, 0, 0, 1'b1);
        send_scale(0, 16'sh4000, 0, 1'b0);
        send_scale(0, 16'sh4000, 0, 1'b0);
        send_scale(0, 0, -16'sh4000, 1'b1);
        send_scale(16'sh0001, -16'sh0001, 16'sh0001, 1'b1);
        drain();
    endtask

    // Sixteen scales close a pixel by count, with and without the last flag.
    task automatic test_scale_overflow();
        for (int p = 0; p < 2; p++)
            for (int s = 0; s < MAX_SCALES; s++)
                send_scale(16'sh7FFF, 16'sh8000, shortint'(s * 1000),
                           bit'(p == 1 && s == MAX_SCALES - 1));
        drain();
    endtask

    // Epsilon of zero with an all-zero pixel: both denominators vanish; then a nonzero pixel.
    task automatic test_zero_guard();
        set_regs(16'd0, 16'd10240, 16'd26214);
        send_scale(0, 0, 0, 1'b0);
        send_scale(0, 0, 0, 1'b1);
        send_scale(16'sh2000, 0, 0, 1'b1);
        drain();
    endtask

    // Whole pixels of random scales; a few run to the full sixteen.
    task automatic test_random_pixels(int beats);
        int sent, len;
        sent = 0;
        while (sent < beats) begin
            len = ($urandom_range(9) == 0) ? MAX_SCALES : $urandom_range(1, 5);
            for (int s = 0; s < len; s++)
                send_scale(pick_response(), pick_response(), pick_response(),
                           (s == len - 1) ? ($urandom_range(1) == 1 || len < MAX_SCALES)
                                          : 1'b0);
            sent += len;
        end
        drain();
    endtask

    // Output side: check each accepted result, then redraw the stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (congruency_q.size() == 0) begin
                $error("congruency: unexpected beat, value %0d", o_congruency);
                n_errors++;
            end else begin
                if (o_congruency !== congruency_q[0]) begin
                    $error("congruency: expected %0d, actual %0d",
                           congruency_q[0], o_congruency);
                    n_errors++;
                end
                void'(congruency_q.pop_front());
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        fill_sigmoid_lut();
        eps_reg = 164;
        gain_reg = 10240;
        cutoff_reg = 26214;
        clear_pixel_acc();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_scale_overflow();
        test_zero_guard();

        // register settings, idle mixes, random pixels
        set_regs(16'd1, 16'd0, 16'd0);
        test_random_pixels(120);
        set_regs(16'h3FFF, 16'hFFFF, 16'hFFFF);
        idle_pct = 66;
        test_random_pixels(120);
        set_regs(16'd164, 16'd10240, 16'd26214);
        idle_pct = 0;
        stall_pct = 66;
        test_random_pixels(150);
        idle_pct = 30;
        stall_pct = 30;
        for (int r = 0; r < 3; r++) begin
            set_regs(16'($urandom_range(1, 16383)), 16'($urandom()), 16'($urandom()));
            test_random_pixels(100);
        end
        stall_pct = 0;
        idle_pct = 0;
        drain();

        if (n_errors == 0 && congruency_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pcp_pkg.sv
rtl/pcp_front.sv
rtl/pcp_sqrt.sv
rtl/pcp_div.sv
rtl/phase_congruency_pixel_unit.sv
tb/phase_congruency_pixel_unit_test.sv
